### sv/assert_macros.svh
// Assertion macros shared by the point/segment distance RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Plain property checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
// Same-cycle implication.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif
`endif

### sv/psd_pkg.sv
// Package for the point/segment squared distance pipeline.
// Holds the projection-kind codes and fixed output widths; no dependencies.
package psd_pkg;

    // How the projection parameter t is formed for one word
    typedef enum logic [1:0] {
        TK_DIV  = 2'd0,   // 0 < dot < len: t from the divider
        TK_ZERO = 2'd1,   // zero length or at/behind start: t = 0
        TK_FULL = 2'd2    // at or beyond end: t = 1.0
    } tkind_t;

    localparam int DIST_BITS   = 36;
    localparam int OUT_TDATA_W = ((DIST_BITS + 7) / 8) * 8;

endpackage

### sv/psd_setup.sv
// Front end: direction/offset vectors, products, dot and squared length, t kind.
// Depends on psd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psd_setup #(
    parameter int COORD_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic                           in_ray,
    input  logic signed [COORD_BITS-1:0]   in_pt  [3],
    input  logic signed [COORD_BITS-1:0]   in_st  [3],
    input  logic signed [COORD_BITS-1:0]   in_end [3],
    output logic                           out_valid,
    output psd_pkg::tkind_t                out_kind,
    output logic [2*COORD_BITS+1:0]        out_num,
    output logic [2*COORD_BITS+1:0]        out_den,
    output logic signed [COORD_BITS:0]     out_d  [3],
    output logic signed [COORD_BITS:0]     out_w  [3]
);

    localparam int DW   = COORD_BITS + 1;
    localparam int PW   = 2 * DW;
    localparam int DOTW = PW + 2;
    localparam int LENW = 2 * COORD_BITS + 2;

    // stage 1
    logic                 v1_reg;
    logic signed [DW-1:0] d1_reg [3];
    logic signed [DW-1:0] w1_reg [3];
    logic signed [DW-1:0] d1_next [3];
    logic signed [DW-1:0] w1_next [3];
    // stage 2
    logic                 v2_reg;
    logic signed [PW-1:0] wd2_reg [3];
    logic signed [PW-1:0] dd2_reg [3];
    logic signed [DW-1:0] d2_reg [3];
    logic signed [DW-1:0] w2_reg [3];
    // stage 3
    logic                   v3_reg;
    psd_pkg::tkind_t        kind3_reg;
    psd_pkg::tkind_t        kind3_next;
    logic [LENW-1:0]        num3_reg;
    logic [LENW-1:0]        num3_next;
    logic [LENW-1:0]        den3_reg;
    logic [LENW-1:0]        len_sum;
    logic signed [DOTW-1:0] dot_sum;
    logic signed [DW-1:0]   d3_reg [3];
    logic signed [DW-1:0]   w3_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            w1_next[i] = DW'(in_pt[i]) - DW'(in_st[i]);
            d1_next[i] = in_ray ? DW'(in_end[i]) : DW'(in_end[i]) - DW'(in_st[i]);
        end
    end

    always_comb
    begin
        dot_sum = DOTW'(wd2_reg[0]) + DOTW'(wd2_reg[1]) + DOTW'(wd2_reg[2]);
        len_sum = LENW'(unsigned'(dd2_reg[0])) + LENW'(unsigned'(dd2_reg[1]))
                + LENW'(unsigned'(dd2_reg[2]));
        num3_next = '0;
        if (len_sum == '0 || dot_sum <= 0)
        begin
            kind3_next = psd_pkg::TK_ZERO;
        end
        else if (dot_sum >= $signed({2'b00, len_sum}))
        begin
            kind3_next = psd_pkg::TK_FULL;
        end
        else
        begin
            kind3_next = psd_pkg::TK_DIV;
            num3_next  = LENW'(dot_sum);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i]  <= d1_next[i];
                w1_reg[i]  <= w1_next[i];
                wd2_reg[i] <= w1_reg[i] * d1_reg[i];
                dd2_reg[i] <= d1_reg[i] * d1_reg[i];
                d2_reg[i]  <= d1_reg[i];
                w2_reg[i]  <= w1_reg[i];
                d3_reg[i]  <= d2_reg[i];
                w3_reg[i]  <= w2_reg[i];
            end
            kind3_reg <= kind3_next;
            num3_reg  <= num3_next;
            den3_reg  <= len_sum;
        end
    end

    assign out_valid = v3_reg;
    assign out_kind  = kind3_reg;
    assign out_num   = num3_reg;
    assign out_den   = den3_reg;
    assign out_d     = d3_reg;
    assign out_w     = w3_reg;

    // divide path only ever sees a proper fraction
    `ASSERT_IMPLY(a_div_frac, clk, rst_n, v3_reg && kind3_reg == psd_pkg::TK_DIV,
                  num3_reg != '0 && num3_reg < den3_reg)

endmodule

### sv/psd_div_step.sv
// One restoring-divider step: one quotient bit per register stage.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module psd_div_step #(
    parameter int RW  = 35,
    parameter int QW  = 14,
    parameter int SBW = 104
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [RW-1:0]  in_rem,
    input  logic [RW-1:0]  in_den,
    input  logic [QW-1:0]  in_quo,
    input  logic [SBW-1:0] in_side,
    output logic           out_valid,
    output logic [RW-1:0]  out_rem,
    output logic [RW-1:0]  out_den,
    output logic [QW-1:0]  out_quo,
    output logic [SBW-1:0] out_side
);

    logic           valid_reg;
    logic [RW-1:0]  rem_reg;
    logic [RW-1:0]  rem_next;
    logic [RW-1:0]  den_reg;
    logic [QW-1:0]  quo_reg;
    logic [QW-1:0]  quo_next;
    logic [SBW-1:0] side_reg;
    logic [RW-1:0]  shifted;
    logic           ge;

    always_comb
    begin
        shifted  = {in_rem[RW-2:0], 1'b0};
        ge       = shifted >= in_den;
        rem_next = ge ? shifted - in_den : shifted;
        quo_next = {in_quo[QW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            den_reg  <= in_den;
            quo_reg  <= quo_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_den   = den_reg;
    assign out_quo   = quo_reg;
    assign out_side  = side_reg;

    // partial remainder stays below the divisor
    `ASSERT_IMPLY(a_rem_bound, clk, rst_n, valid_reg, rem_reg < den_reg || den_reg == '0)

endmodule

### sv/psd_finish.sv
// Back end: t select, closest-point offsets, squares and final sum (output register).
// Depends on psd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module psd_finish #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  psd_pkg::tkind_t                   in_kind,
    input  logic [FRAC_BITS-1:0]              in_quo,
    input  logic signed [COORD_BITS:0]        in_d [3],
    input  logic signed [COORD_BITS:0]        in_w [3],
    output logic                              out_valid,
    output logic [psd_pkg::DIST_BITS-1:0]     out_dist
);

    localparam int DW   = COORD_BITS + 1;
    localparam int TW   = FRAC_BITS + 1;
    localparam int MW   = DW + TW + 1;
    localparam int DFW  = COORD_BITS + 3;
    localparam int SQW  = 2 * DFW;
    localparam int ACCW = SQW + 2;
    localparam logic signed [DFW-1:0] DIFF_MAX = {2'b01, {(COORD_BITS + 1){1'b0}}};
    localparam logic signed [DFW-1:0] DIFF_MIN = {2'b11, {(COORD_BITS + 1){1'b0}}};

    logic [TW-1:0]         t_sel;
    // F1
    logic                  v1_reg;
    logic signed [MW-1:0]  prod1_reg [3];
    logic signed [DW-1:0]  w1_reg [3];
    // F2
    logic                  v2_reg;
    logic signed [DFW-1:0] diff2_reg [3];
    logic signed [DFW-1:0] diff2_next [3];
    // F3
    logic                  v3_reg;
    logic [SQW-1:0]        sq3_reg [3];
    logic [SQW-1:0]        sq3_next [3];
    // output
    logic                           v4_reg;
    logic [psd_pkg::DIST_BITS-1:0]  dist_reg;
    logic [ACCW-1:0]                acc;

    always_comb
    begin
        case (in_kind)
            psd_pkg::TK_DIV:  t_sel = {1'b0, in_quo};
            psd_pkg::TK_FULL: t_sel = {1'b1, {FRAC_BITS{1'b0}}};
            psd_pkg::TK_ZERO: t_sel = '0;
            default:          t_sel = '0;
        endcase
    end

    always_comb
    begin
        logic signed [MW-1:0]  shifted;
        logic signed [SQW-1:0] sq_s;
        shifted = '0;
        sq_s    = '0;
        for (int i = 0; i < 3; i++)
        begin
            // floor shift of d*t, then (start + that) - point == that - w
            shifted       = prod1_reg[i] >>> FRAC_BITS;
            diff2_next[i] = DFW'(shifted) - DFW'(w1_reg[i]);
            sq_s          = diff2_reg[i] * diff2_reg[i];
            sq3_next[i]   = unsigned'(sq_s);
        end
        acc = ACCW'(sq3_reg[0]) + ACCW'(sq3_reg[1]) + ACCW'(sq3_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod1_reg[i] <= in_d[i] * $signed({1'b0, t_sel});
                w1_reg[i]    <= in_w[i];
                diff2_reg[i] <= diff2_next[i];
                sq3_reg[i]   <= sq3_next[i];
            end
            dist_reg <= psd_pkg::DIST_BITS'(acc);
        end
    end

    assign out_valid = v4_reg;
    assign out_dist  = dist_reg;

    // offset to the closest point never exceeds two coordinate spans
    for (genvar g = 0; g < 3; g++)
    begin : g_diff_chk
        `ASSERT_IMPLY(a_diff_range, clk, rst_n, v2_reg, diff2_reg[g] <= DIFF_MAX && diff2_reg[g] >= DIFF_MIN)
    end

endmodule

### sv/point_segment_distance_sq.sv
// point_segment_distance_sq: 3 setup stages, FRAC_BITS divider stages and 4 back-end
// stages from accept to m_tvalid. Throughput one word per cycle while m_tready does
// not stall the pipe; the one-bit-per-stage divider sets the depth.
// The whole pipe advances together when the output register is empty or taken.
// rst_n (async, active low) clears only the valid bits and holds s_tready low.
// Depends on psd_pkg, psd_setup, psd_div_step, psd_finish.

module point_segment_distance_sq #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [((9*COORD_BITS+7)/8)*8-1:0]   s_tdata,
    // func (1 = end fields carry a direction)
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // dist_sq, zero padded to whole bytes
    output logic [psd_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int DW   = COORD_BITS + 1;
    localparam int LENW = 2 * COORD_BITS + 2;
    localparam int RW   = LENW + 1;   // room for the remainder shifted left once
    localparam int KW   = $bits(psd_pkg::tkind_t);
    localparam int SBW  = KW + 6 * DW;

    logic en;

    logic signed [COORD_BITS-1:0] pt  [3];
    logic signed [COORD_BITS-1:0] st  [3];
    logic signed [COORD_BITS-1:0] sg_end [3];

    logic                 setup_valid;
    psd_pkg::tkind_t      setup_kind;
    logic [LENW-1:0]      setup_num;
    logic [LENW-1:0]      setup_den;
    logic signed [DW-1:0] setup_d [3];
    logic signed [DW-1:0] setup_w [3];

    // divider chain taps, index 0 is the chain input
    logic                 v_c    [FRAC_BITS+1];
    logic [RW-1:0]        rem_c  [FRAC_BITS+1];
    logic [RW-1:0]        den_c  [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] quo_c  [FRAC_BITS+1];
    logic [SBW-1:0]       side_c [FRAC_BITS+1];

    psd_pkg::tkind_t      fin_kind;
    logic signed [DW-1:0] fin_d [3];
    logic signed [DW-1:0] fin_w [3];
    logic [psd_pkg::DIST_BITS-1:0] dist_sq;

    // global advance: output register free or being drained
    assign en       = !m_tvalid || m_tready;
    assign s_tready = rst_n && en;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pt[i]     = s_tdata[i*COORD_BITS +: COORD_BITS];
            st[i]     = s_tdata[(3+i)*COORD_BITS +: COORD_BITS];
            sg_end[i] = s_tdata[(6+i)*COORD_BITS +: COORD_BITS];
        end
    end

    psd_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_ray    (s_tuser),
        .in_pt     (pt),
        .in_st     (st),
        .in_end    (sg_end),
        .out_valid (setup_valid),
        .out_kind  (setup_kind),
        .out_num   (setup_num),
        .out_den   (setup_den),
        .out_d     (setup_d),
        .out_w     (setup_w)
    );

    // kind, d and w ride alongside the divider
    assign v_c[0]    = setup_valid;
    assign rem_c[0]  = {1'b0, setup_num};
    assign den_c[0]  = {1'b0, setup_den};
    assign quo_c[0]  = '0;
    assign side_c[0] = {setup_kind, setup_d[0], setup_d[1], setup_d[2],
                        setup_w[0], setup_w[1], setup_w[2]};

    for (genvar s = 0; s < FRAC_BITS; s++)
    begin : g_div
        psd_div_step #(
            .RW  (RW),
            .QW  (FRAC_BITS),
            .SBW (SBW)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (v_c[s]),
            .in_rem    (rem_c[s]),
            .in_den    (den_c[s]),
            .in_quo    (quo_c[s]),
            .in_side   (side_c[s]),
            .out_valid (v_c[s+1]),
            .out_rem   (rem_c[s+1]),
            .out_den   (den_c[s+1]),
            .out_quo   (quo_c[s+1]),
            .out_side  (side_c[s+1])
        );
    end

    // the last remainder and divisor are not needed past the divider
    assign fin_kind = psd_pkg::tkind_t'(side_c[FRAC_BITS][SBW-1 -: KW]);
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fin_d[i] = side_c[FRAC_BITS][(5-i)*DW +: DW];
            fin_w[i] = side_c[FRAC_BITS][(2-i)*DW +: DW];
        end
    end

    psd_finish #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_c[FRAC_BITS]),
        .in_kind   (fin_kind),
        .in_quo    (quo_c[FRAC_BITS]),
        .in_d      (fin_d),
        .in_w      (fin_w),
        .out_valid (m_tvalid),
        .out_dist  (dist_sq)
    );

    assign m_tdata = {{(psd_pkg::OUT_TDATA_W - psd_pkg::DIST_BITS){1'b0}}, dist_sq};

endmodule
